// ----- rtl/cssm_pkg.sv -----
`default_nettype none
package cssm_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_STRING  = 2'd1,
    MODE_COMMENT = 2'd2
  } mode_t;

  // One accepted input byte, after classification: up to two output bytes.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       two;      // byte1 follows byte0
    logic       present;  // byte0 is real; clear for a bare end marker
    logic       done;     // last input byte of the text
  } entry_t;

  localparam logic [7:0] CH_LBRACE    = 8'h7b;
  localparam logic [7:0] CH_RBRACE    = 8'h7d;
  localparam logic [7:0] CH_COLON     = 8'h3a;
  localparam logic [7:0] CH_SEMI      = 8'h3b;
  localparam logic [7:0] CH_COMMA     = 8'h2c;
  localparam logic [7:0] CH_GT        = 8'h3e;
  localparam logic [7:0] CH_SLASH     = 8'h2f;
  localparam logic [7:0] CH_STAR      = 8'h2a;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0a;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  function automatic logic is_structural(input logic [7:0] c);
    return c inside {CH_LBRACE, CH_RBRACE, CH_COLON, CH_SEMI, CH_COMMA, CH_GT};
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/css_whitespace_comment_stripper.sv -----
// CSS minifier: strips block comments and collapses whitespace.
// Input channel: text_valid/text_ready with text_byte and final_byte; final_byte
// marks the last byte of one stylesheet text.
// Output channel: result_valid/result_ready with out_byte, byte_present and
// text_done. byte_present low means a bare end marker (out_byte is 0);
// text_done is high on the last result caused by the final byte.
// Throughput: one input byte per cycle while the queue has room. Each byte
// yields zero, one or two results; the output side sends one per cycle while
// result_ready is high, so a byte with two results takes two output transfers.
// An accepted byte's results are written into the queue and offered from its
// head; result_valid is high whenever the queue is not empty.
// A QUEUE_DEPTH-entry queue between the scanner and the output serializer
// absorbs output stalls; text_ready drops only when the queue is full.
// Reset empties the queue and returns the scanner to normal mode. Scanner
// state also returns to reset after every final byte.
`default_nettype none
module css_whitespace_comment_stripper
  import cssm_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       text_valid,
  output logic            text_ready,
  input  wire logic [7:0] text_byte,
  input  wire logic       final_byte,
  output logic            result_valid,
  input  wire logic       result_ready,
  output logic [7:0]      out_byte,
  output logic            byte_present,
  output logic            text_done
);

  logic   q_full, q_not_empty, push, pop;
  entry_t push_entry, head;

  cssm_front u_front (
    .clk, .rst, .text_valid, .text_ready, .text_byte, .final_byte,
    .q_full, .push, .push_entry
  );

  cssm_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk, .rst, .push, .push_entry, .pop,
    .full(q_full), .not_empty(q_not_empty), .head
  );

  cssm_back u_back (
    .clk, .rst, .not_empty(q_not_empty), .head, .pop,
    .result_valid, .result_ready, .out_byte, .byte_present, .text_done
  );

endmodule
`default_nettype wire

// ----- rtl/cssm_front.sv -----
`default_nettype none
module cssm_front
  import cssm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       text_valid,
  output logic            text_ready,
  input  wire logic [7:0] text_byte,
  input  wire logic       final_byte,
  input  wire logic       q_full,
  output logic            push,
  output entry_t          push_entry
);

  mode_t mode, mode_next;
  logic  quote_is_double, quote_is_double_next;
  logic  prior_was_backslash, prior_was_backslash_next;
  logic  star_seen, star_seen_next;
  logic  slash_held, slash_held_next;
  logic  space_pending, space_pending_next;
  logic  anything_emitted, anything_emitted_next;
  logic  last_structural, last_structural_next;

  logic       accept;
  logic [1:0] cnt;
  logic [7:0] b0, b1;
  logic [7:0] quote_ch;
  logic       do_plain;

  assign text_ready = !q_full;
  assign accept     = text_valid && text_ready;

  // Emission order: slot 0, then slot 1; a third byte is dropped but still
  // updates the emitted-byte history.
  always_comb begin
    mode_next                = mode;
    quote_is_double_next     = quote_is_double;
    prior_was_backslash_next = prior_was_backslash;
    star_seen_next           = star_seen;
    slash_held_next          = slash_held;
    space_pending_next       = space_pending;
    anything_emitted_next    = anything_emitted;
    last_structural_next     = last_structural;
    cnt      = 2'd0;
    b0       = 8'h00;
    b1       = 8'h00;
    do_plain = 1'b0;
    quote_ch = quote_is_double ? CH_DQUOTE : CH_SQUOTE;

    case (mode)
      MODE_STRING: begin
        b0 = text_byte;
        cnt = 2'd1;
        anything_emitted_next = 1'b1;
        last_structural_next  = is_structural(text_byte);
        if (text_byte == quote_ch && !prior_was_backslash) begin
          mode_next = MODE_NORMAL;
          prior_was_backslash_next = 1'b0;
        end else begin
          prior_was_backslash_next = (text_byte == CH_BACKSLASH);
        end
      end
      MODE_COMMENT: begin
        if (star_seen && text_byte == CH_SLASH) begin
          mode_next = MODE_NORMAL;
          star_seen_next = 1'b0;
        end else begin
          star_seen_next = (text_byte == CH_STAR);
        end
      end
      default: begin
        do_plain = 1'b1;
        if (slash_held) begin
          slash_held_next = 1'b0;
          if (text_byte == CH_STAR) begin
            mode_next      = MODE_COMMENT;
            star_seen_next = 1'b0;
            do_plain       = 1'b0;
          end else begin
            b0  = CH_SLASH;
            cnt = 2'd1;
            anything_emitted_next = 1'b1;
            last_structural_next  = 1'b0;
          end
        end
      end
    endcase

    if (do_plain) begin
      if (is_blank(text_byte)) begin
        if (anything_emitted_next) space_pending_next = 1'b1;
      end else begin
        if (space_pending_next) begin
          space_pending_next = 1'b0;
          if (!last_structural_next && !is_structural(text_byte)) begin
            if (cnt == 2'd0) b0 = CH_SPACE;
            else if (cnt == 2'd1) b1 = CH_SPACE;
            if (cnt != 2'd2) cnt = cnt + 2'd1;
            anything_emitted_next = 1'b1;
            last_structural_next  = 1'b0;
          end
        end
        if (text_byte == CH_SLASH) begin
          slash_held_next = 1'b1;
        end else begin
          if (text_byte == CH_SQUOTE || text_byte == CH_DQUOTE) begin
            mode_next                = MODE_STRING;
            quote_is_double_next     = (text_byte == CH_DQUOTE);
            prior_was_backslash_next = 1'b0;
          end
          if (cnt == 2'd0) b0 = text_byte;
          else if (cnt == 2'd1) b1 = text_byte;
          if (cnt != 2'd2) cnt = cnt + 2'd1;
          anything_emitted_next = 1'b1;
          last_structural_next  = is_structural(text_byte);
        end
      end
    end

    // held slash flushes at end of text
    if (final_byte && slash_held_next) begin
      if (cnt == 2'd0) b0 = CH_SLASH;
      else if (cnt == 2'd1) b1 = CH_SLASH;
      if (cnt != 2'd2) cnt = cnt + 2'd1;
    end

    if (final_byte) begin
      mode_next                = MODE_NORMAL;
      quote_is_double_next     = 1'b0;
      prior_was_backslash_next = 1'b0;
      star_seen_next           = 1'b0;
      slash_held_next          = 1'b0;
      space_pending_next       = 1'b0;
      anything_emitted_next    = 1'b0;
      last_structural_next     = 1'b0;
    end
  end

  assign push               = accept && (cnt != 2'd0 || final_byte);
  assign push_entry.byte0   = b0;
  assign push_entry.byte1   = b1;
  assign push_entry.two     = (cnt == 2'd2);
  assign push_entry.present = (cnt != 2'd0);
  assign push_entry.done    = final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode                <= MODE_NORMAL;
      quote_is_double     <= 1'b0;
      prior_was_backslash <= 1'b0;
      star_seen           <= 1'b0;
      slash_held          <= 1'b0;
      space_pending       <= 1'b0;
      anything_emitted    <= 1'b0;
      last_structural     <= 1'b0;
    end else if (accept) begin
      mode                <= mode_next;
      quote_is_double     <= quote_is_double_next;
      prior_was_backslash <= prior_was_backslash_next;
      star_seen           <= star_seen_next;
      slash_held          <= slash_held_next;
      space_pending       <= space_pending_next;
      anything_emitted    <= anything_emitted_next;
      last_structural     <= last_structural_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cssm_fifo.sv -----
`default_nettype none
module cssm_fifo
  import cssm_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output logic        full,
  output logic        not_empty,
  output entry_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wptr, rptr;
  logic [CNT_W-1:0]   count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      if (pop)  rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cssm_back.sv -----
`default_nettype none
module cssm_back
  import cssm_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   not_empty,
  input  wire entry_t head,
  output logic        pop,
  output logic        result_valid,
  input  wire logic   result_ready,
  output logic [7:0]  out_byte,
  output logic        byte_present,
  output logic        text_done
);

  logic second;   // head entry's first byte already delivered
  logic last_part;
  logic xfer;

  assign last_part    = second || !head.two;
  assign result_valid = not_empty;
  assign xfer         = result_valid && result_ready;
  assign pop          = xfer && last_part;
  assign out_byte     = second ? head.byte1 : head.byte0;
  assign byte_present = second || head.present;
  assign text_done    = head.done && last_part;

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (xfer) begin
      second <= !last_part;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cssm_checker.sv -----
`default_nettype none
module cssm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       text_valid,
  input wire logic       text_ready,
  input wire logic       result_valid,
  input wire logic       result_ready,
  input wire logic [7:0] out_byte,
  input wire logic       byte_present,
  input wire logic       text_done
);

  // nothing is offered right after reset
  a_idle_after_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result offered after reset");

  // a bare marker only ends a text, and carries a zero byte
  a_bare_is_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && !byte_present |-> text_done && out_byte == 8'h00)
    else $error("bare result without end of text or with nonzero byte");

  // a result with no prior input cannot appear out of an empty pipe
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    !result_valid && !(text_valid && text_ready) |=> !result_valid)
    else $error("result appeared without an accepted input");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result_valid dropped before acceptance");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      $stable(out_byte) && $stable(byte_present) && $stable(text_done))
    else $error("stalled result payload changed");

endmodule

bind css_whitespace_comment_stripper cssm_checker u_cssm_checker (.*);
`default_nettype wire

// ----- dv/css_whitespace_comment_stripper_test.sv -----
module css_whitespace_comment_stripper_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cssm_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       present;
    logic       done;
  } css_out_t;

  class minified_stream_checker;
    mode_t    scan;
    bit       dq;
    bit       after_bslash;
    bit       star_prev;
    bit       slash_wait;
    bit       gap_pending;
    bit       emitted_any;
    bit       last_punct;
    css_out_t expected_out[$];
    css_out_t step_out[$];
    int       errors;
    int       checked;
    int       bare_markers;

    function new();
      clear_scan();
    endfunction

    function void clear_scan();
      scan         = MODE_NORMAL;
      dq           = 1'b0;
      after_bslash = 1'b0;
      star_prev    = 1'b0;
      slash_wait   = 1'b0;
      gap_pending  = 1'b0;
      emitted_any  = 1'b0;
      last_punct   = 1'b0;
    endfunction

    function bit punct(logic [7:0] c);
      case (c)
        CH_LBRACE, CH_RBRACE, CH_COLON, CH_SEMI, CH_COMMA, CH_GT: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function bit blank(logic [7:0] c);
      case (c)
        CH_SPACE, CH_TAB, CH_LF, CH_CR: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void emit_char(logic [7:0] c);
      if (step_out.size() < 2)
        step_out.push_back(css_out_t'{ch: c, present: 1'b1, done: 1'b0});
      emitted_any = 1'b1;
      last_punct  = punct(c);
    endfunction

    // byte outside strings and comments, any held slash already settled
    function void outside(logic [7:0] c);
      if (blank(c)) begin
        if (emitted_any) gap_pending = 1'b1;
        return;
      end
      if (gap_pending) begin
        gap_pending = 1'b0;
        if (!last_punct && !punct(c)) emit_char(CH_SPACE);
      end
      if (c == CH_SLASH) begin
        slash_wait = 1'b1;
      end else begin
        if (c == CH_SQUOTE || c == CH_DQUOTE) begin
          scan         = MODE_STRING;
          dq           = (c == CH_DQUOTE);
          after_bslash = 1'b0;
        end
        emit_char(c);
      end
    endfunction

    function void take_source_byte(logic [7:0] c, logic is_last);
      step_out.delete();
      case (scan)
        MODE_STRING: begin
          emit_char(c);
          if (c == (dq ? CH_DQUOTE : CH_SQUOTE) && !after_bslash) begin
            scan         = MODE_NORMAL;
            after_bslash = 1'b0;
          end else begin
            after_bslash = (c == CH_BACKSLASH);
          end
        end
        MODE_COMMENT: begin
          if (star_prev && c == CH_SLASH) begin
            scan      = MODE_NORMAL;
            star_prev = 1'b0;
          end else begin
            star_prev = (c == CH_STAR);
          end
        end
        default: begin
          if (slash_wait) begin
            slash_wait = 1'b0;
            if (c == CH_STAR) begin
              scan      = MODE_COMMENT;
              star_prev = 1'b0;
            end else begin
              emit_char(CH_SLASH);
              outside(c);
            end
          end else begin
            outside(c);
          end
        end
      endcase
      if (is_last) begin
        if (slash_wait) emit_char(CH_SLASH);
        if (step_out.size() == 0) begin
          step_out.push_back(css_out_t'{ch: 8'h00, present: 1'b0, done: 1'b0});
          bare_markers++;
        end
        step_out[step_out.size() - 1].done = 1'b1;
        clear_scan();
      end
      foreach (step_out[i]) expected_out.push_back(step_out[i]);
    endfunction

    function void check_minified(logic [7:0] ch, logic present, logic done);
      css_out_t want;
      if (expected_out.size() == 0) begin
        $display("%0t: unexpected result out_byte=%h byte_present=%b text_done=%b",
                 $time, ch, present, done);
        errors++;
        return;
      end
      want = expected_out.pop_front();
      checked++;
      if (want.ch !== ch) begin
        $display("%0t: out_byte mismatch: expected %h, got %h", $time, want.ch, ch);
        errors++;
      end
      if (want.present !== present) begin
        $display("%0t: byte_present mismatch: expected %b, got %b",
                 $time, want.present, present);
        errors++;
      end
      if (want.done !== done) begin
        $display("%0t: text_done mismatch: expected %b, got %b", $time, want.done, done);
        errors++;
      end
    endfunction

    function void finish_check();
      if (expected_out.size() != 0) begin
        $display("%0t: %0d expected results never arrived, oldest out_byte=%h",
                 $time, expected_out.size(), expected_out[0].ch);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       text_valid;
  logic       text_ready;
  logic [7:0] text_byte;
  logic       final_byte;
  logic       result_valid;
  logic       result_ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       text_done;

  minified_stream_checker sb;
  logic [7:0] text_buf[$];
  int idle_pct;
  int stall_pct;
  bit hold_go;
  int hold_left;
  int bytes_sent;
  int texts_sent;

  css_whitespace_comment_stripper dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text_byte    (text_byte),
    .final_byte   (final_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_byte     (out_byte),
    .byte_present (byte_present),
    .text_done    (text_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (text_valid && text_ready) sb.take_source_byte(text_byte, final_byte);
      if (result_valid && result_ready) sb.check_minified(out_byte, byte_present, text_done);
    end
  end

  // output side: random stalls, plus a long hold-off on request
  initial begin
    result_ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic offer_byte(input logic [7:0] b, input logic fin);
    if ($urandom_range(99) < idle_pct) begin
      text_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    text_valid <= 1'b1;
    text_byte  <= b;
    final_byte <= fin;
    @(posedge clk);
    while (!text_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_buf[i]) offer_byte(text_buf[i], i == text_buf.size() - 1);
    texts_sent++;
  endtask

  // wait for the clock first so the last accepted byte is already in the scoreboard
  task automatic drain();
    text_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_out.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_punct();
    case ($urandom_range(0, 5))
      0: return CH_LBRACE;
      1: return CH_RBRACE;
      2: return CH_COLON;
      3: return CH_SEMI;
      4: return CH_COMMA;
      default: return CH_GT;
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  // mostly stylesheet-like pieces; one text in five is raw byte noise
  task automatic build_css_text();
    string word_chars;
    string note_chars;
    string str_chars;
    logic [7:0] q;
    word_chars = "abcdefghijklmnopqrstuvwxyz0123456789#.-%()!";
    note_chars = "*/ a*x{";
    str_chars  = "a \\'\"/*;{";
    text_buf.delete();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(2, 7)) begin
      case ($urandom_range(0, 9))
        0, 1: repeat ($urandom_range(1, 4))
          text_buf.push_back(word_chars[$urandom_range(0, word_chars.len() - 1)]);
        2, 3: repeat ($urandom_range(1, 3)) text_buf.push_back(pick_blank());
        4: text_buf.push_back(pick_punct());
        5: begin
          text_buf.push_back(CH_SLASH);
          text_buf.push_back(CH_STAR);
          repeat ($urandom_range(0, 4))
            text_buf.push_back(note_chars[$urandom_range(0, note_chars.len() - 1)]);
          if ($urandom_range(0, 4) != 0) begin
            text_buf.push_back(CH_STAR);
            text_buf.push_back(CH_SLASH);
          end
        end
        6: begin
          q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
          text_buf.push_back(q);
          repeat ($urandom_range(0, 4))
            text_buf.push_back(str_chars[$urandom_range(0, str_chars.len() - 1)]);
          if ($urandom_range(0, 4) != 0) text_buf.push_back(q);
        end
        7: text_buf.push_back(CH_SLASH);
        8: text_buf.push_back(8'($urandom_range(0, 255)));
        default: begin
          text_buf.push_back(pick_blank());
          text_buf.push_back(pick_punct());
        end
      endcase
    end
  endtask

  initial begin
    int phase_bytes;
    sb = new();
    rst        <= 1'b1;
    text_valid <= 1'b0;
    text_byte  <= 8'h00;
    final_byte <= 1'b0;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_go    = 1'b0;
    bytes_sent = 0;
    texts_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed texts
    text_buf = '{8'hFF};
    send_text();
    text_buf = '{CH_SPACE, "x", CH_SPACE, CH_SLASH};   // held slash flushed at end
    send_text();
    text_buf = '{CH_SLASH, CH_STAR, CH_SLASH, CH_STAR, CH_SLASH};  // opening star not a close
    send_text();
    text_buf = '{CH_SQUOTE, CH_BACKSLASH, CH_SQUOTE, 8'hFF};  // escaped quote, open string
    send_text();
    text_buf = '{"a", CH_SPACE, CH_DQUOTE};
    send_text();
    text_buf = '{CH_SLASH, "x", CH_SLASH, CH_STAR};   // comment left open at end
    send_text();
    text_buf = '{CH_COMMA, CH_TAB, CH_GT};
    send_text();
    text_buf = '{8'h00};
    send_text();
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      if (p == 0) hold_go = 1'b1;
      phase_bytes = bytes_sent;
      while (bytes_sent - phase_bytes < 125) begin
        build_css_text();
        send_text();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    sb.finish_check();
    $display("Sent %0d bytes in %0d texts; compared %0d results, %0d of them end-only markers.",
             bytes_sent, texts_sent, sb.checked, sb.bare_markers);
    $display("Phases: directed cases, free-running with a long output hold, input gaps,"
             , " output stalls, and both mixed.");
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
